### rtl/core/stpd_pkg.sv
// Package for the spectral tone peak detector: payload and queue entry types,
// configuration layout, register codes and fixed arithmetic constants.
// No dependencies.
package stpd_pkg;

    localparam int HALF_BINS_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int MAG_W   = 48;
    localparam int SMP_W   = 24;
    localparam int FREQ_W  = 12;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Front pipe depth and the width of its occupancy count
    localparam int FRONT_LAT = 3;
    localparam int INFL_W    = 2;

    // Rounded frequency: floor((t >> 2) / 25) by reciprocal, exact for t < 2**24
    localparam int T_W      = 24;
    localparam int U_W      = 22;
    localparam int RECIP_W  = 23;
    localparam int RECIP_SH = 27;
    localparam int QP_W     = U_W + RECIP_W;
    localparam int Q_W      = QP_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP      = 23'd5368710;
    localparam logic [T_W-1:0]     FREQ_ROUND = 24'd50;
    localparam logic [Q_W-1:0]     FREQ_MAX   = 18'd4095;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd1024;

    localparam logic [7:0]        BIN_STEP_RST   = 8'd21;
    localparam logic [MAG_W-1:0]  THRESHOLD_RST  = 48'd100000000;
    localparam logic [FREQ_W-1:0] TONE_FLOOR_RST = 12'd190;
    localparam logic [FREQ_W-1:0] TONE_BASE_RST  = 12'd195;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_STEP   = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_TONE_FLOOR = 2'd2,
        CFG_TONE_BASE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] bin_re;
        logic signed [SMP_W-1:0] bin_im;
        logic                    last_bin;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  tone_word;
        logic [COUNT_W-1:0] peak_count;
        logic [FREQ_W-1:0]  last_tone;
    } result_t;

    typedef struct packed {
        logic [7:0]        bin_step;
        logic [MAG_W-1:0]  level_threshold_sq;
        logic [FREQ_W-1:0] tone_floor;
        logic [FREQ_W-1:0] tone_base;
    } cfg_t;

    // One classified bin as handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [FREQ_W-1:0] freq;
        logic              det_ok;
        logic              in_word;
        logic [POS_W-1:0]  bit_pos;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic room;
    } fifo_stat_t;

endpackage

### rtl/core/stpd_front.sv
// Front of the peak detector: accepts bins, squares magnitudes, works out the
// rounded bin frequency and classifies it against floor and base.
// Depends on stpd_pkg.
module stpd_front #(
    parameter int HALF_BINS = stpd_pkg::HALF_BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stpd_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  stpd_pkg::item_t                  item,
    input  stpd_pkg::fifo_stat_t             fifo_stat,
    output logic                             push,
    output stpd_pkg::entry_t                 entry,
    output logic [stpd_pkg::INFL_W-1:0]      inflight
);

    localparam int IDX_W = $clog2(HALF_BINS);
    localparam int FP_W  = IDX_W + 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HALF_BINS - 1);

    logic                         accept;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic signed [stpd_pkg::MAG_W-1:0] sq_re, sq_im;
    logic [stpd_pkg::MAG_W-1:0]   sq_re_reg, sq_im_reg;
    logic [FP_W-1:0]              fprod_reg;
    logic                         s1_det_reg, s1_last_reg;

    logic [stpd_pkg::T_W-1:0]     t_val;
    logic [stpd_pkg::QP_W-1:0]    qprod_reg;
    logic [stpd_pkg::MAG_W-1:0]   mag_reg, mag_s3_reg;
    logic                         s2_det_reg, s2_last_reg, s3_det_reg, s3_last_reg;

    logic [stpd_pkg::Q_W-1:0]     quot_reg;
    logic [stpd_pkg::FREQ_W-1:0]  freq;
    logic [stpd_pkg::FREQ_W-1:0]  offset;

    assign item_ready = fifo_stat.room;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (item.last_bin)
                idx_next = '0;
            else if (idx_reg != LAST_IDX)
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign sq_re = item.bin_re * item.bin_re;
    assign sq_im = item.bin_im * item.bin_im;
    assign t_val = stpd_pkg::T_W'(fprod_reg >> 1) + stpd_pkg::FREQ_ROUND;

    always_ff @(posedge clk)
    begin
        // stage 1: squares and frequency product of the previous bin
        sq_re_reg   <= sq_re;
        sq_im_reg   <= sq_im;
        fprod_reg   <= FP_W'(idx_reg - IDX_W'(1)) * FP_W'(cfg.bin_step);
        s1_det_reg  <= (idx_reg >= IDX_W'(2));
        s1_last_reg <= item.last_bin;
        // stage 2: magnitude and reciprocal product
        mag_reg     <= sq_re_reg + sq_im_reg;
        qprod_reg   <= stpd_pkg::QP_W'(t_val[stpd_pkg::T_W-1:2])
                       * stpd_pkg::QP_W'(stpd_pkg::RECIP);
        s2_det_reg  <= s1_det_reg;
        s2_last_reg <= s1_last_reg;
        // stage 3
        mag_s3_reg  <= mag_reg;
        quot_reg    <= qprod_reg[stpd_pkg::QP_W-1:stpd_pkg::RECIP_SH];
        s3_det_reg  <= s2_det_reg;
        s3_last_reg <= s2_last_reg;
    end

    // saturate and classify
    assign freq   = (quot_reg > stpd_pkg::FREQ_MAX) ? stpd_pkg::FREQ_W'(stpd_pkg::FREQ_MAX)
                                                    : quot_reg[stpd_pkg::FREQ_W-1:0];
    assign offset = freq - cfg.tone_base;

    always_comb
    begin
        entry.mag     = mag_s3_reg;
        entry.freq    = freq;
        entry.det_ok  = s3_det_reg && (freq > cfg.tone_floor);
        entry.in_word = (freq >= cfg.tone_base) && (offset < stpd_pkg::FREQ_W'(32));
        entry.bit_pos = offset[stpd_pkg::POS_W-1:0];
        entry.last    = s3_last_reg;
    end

    assign push     = s3_valid_reg;
    assign inflight = stpd_pkg::INFL_W'({1'b0, s1_valid_reg}) + stpd_pkg::INFL_W'(s2_valid_reg)
                      + stpd_pkg::INFL_W'(s3_valid_reg);

endmodule

### rtl/core/stpd_fifo.sv
// Short queue of classified bins between front and back, with a credit check
// that counts items still in the front pipe.
// Depends on stpd_pkg.
module stpd_fifo #(
    parameter int DEPTH = stpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  stpd_pkg::entry_t              wr_entry,
    input  logic                          pop,
    output stpd_pkg::entry_t              rd_entry,
    input  logic [stpd_pkg::INFL_W-1:0]   inflight,
    output stpd_pkg::fifo_stat_t          stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 2;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    stpd_pkg::entry_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    assign rd_entry   = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    // hold a place for every item already in the front pipe
    assign stat.room  = ((count_reg + CNT_W'(inflight)) < CNT_W'(DEPTH));

endmodule

### rtl/core/stpd_back.sv
// Back of the peak detector: keeps the two previous magnitudes, tests for a
// local maximum, accumulates the frame and holds the result register.
// Depends on stpd_pkg.
module stpd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  stpd_pkg::cfg_t            cfg,
    input  stpd_pkg::entry_t          entry,
    input  stpd_pkg::fifo_stat_t      fifo_stat,
    output logic                      pop,
    output logic                      result_valid,
    input  logic                      result_ready,
    output stpd_pkg::result_t         result
);

    logic [stpd_pkg::MAG_W-1:0]   prev_reg, prev2_reg;
    logic [stpd_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [stpd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [stpd_pkg::FREQ_W-1:0]  last_reg, last_next;
    logic                         result_valid_reg, result_valid_next;
    stpd_pkg::result_t            result_reg;
    logic                         peak;
    logic                         load;

    // a frame end waits until the result register is free
    assign pop  = !fifo_stat.empty
                  && (!entry.last || !result_valid_reg || result_ready);
    assign load = pop && entry.last;

    assign peak = entry.det_ok && (prev2_reg < prev_reg) && (prev_reg > entry.mag)
                  && (prev_reg > cfg.level_threshold_sq);

    always_comb
    begin
        word_next  = word_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (peak)
        begin
            if (entry.in_word)
                word_next = word_reg | (stpd_pkg::WORD_W'(1) << entry.bit_pos);
            if (count_reg < stpd_pkg::COUNT_MAX)
                count_next = count_reg + stpd_pkg::COUNT_W'(1);
            last_next = entry.freq;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= '0;
            prev2_reg        <= '0;
            word_reg         <= '0;
            count_reg        <= '0;
            last_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop)
            begin
                if (entry.last)
                begin
                    // clear the frame
                    prev_reg  <= '0;
                    prev2_reg <= '0;
                    word_reg  <= '0;
                    count_reg <= '0;
                    last_reg  <= '0;
                end
                else
                begin
                    prev2_reg <= prev_reg;
                    prev_reg  <= entry.mag;
                    word_reg  <= word_next;
                    count_reg <= count_next;
                    last_reg  <= last_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.tone_word  <= word_next;
            result_reg.peak_count <= count_next;
            result_reg.last_tone  <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/spectral_tone_peak_detector.sv
// Spectral tone peak detector, top level: configuration registers, front,
// queue and back. Depends on stpd_pkg, stpd_front, stpd_fifo and stpd_back.
// Throughput: one bin per cycle, held by the front pipe credit on the queue.
// Path of the last bin to a valid result: three front stages, the first
// loaded at the accepting edge, then the queue and one result register.
// Reset: asynchronous; registers return to defaults, frame state and queue clear.
module spectral_tone_peak_detector #(
    parameter int HALF_BINS   = stpd_pkg::HALF_BINS_DEF,
    parameter int QUEUE_DEPTH = stpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  stpd_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output stpd_pkg::result_t                   result
);

    stpd_pkg::cfg_t                 cfg_reg;
    stpd_pkg::fifo_stat_t           fifo_stat;
    stpd_pkg::entry_t               push_entry, head_entry;
    logic                           push, pop;
    logic [stpd_pkg::INFL_W-1:0]    inflight;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_step           <= stpd_pkg::BIN_STEP_RST;
            cfg_reg.level_threshold_sq <= stpd_pkg::THRESHOLD_RST;
            cfg_reg.tone_floor         <= stpd_pkg::TONE_FLOOR_RST;
            cfg_reg.tone_base          <= stpd_pkg::TONE_BASE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (stpd_pkg::cfg_idx_t'(cfg_index))
                stpd_pkg::CFG_BIN_STEP:   cfg_reg.bin_step           <= cfg_data[7:0];
                stpd_pkg::CFG_THRESHOLD:  cfg_reg.level_threshold_sq <= cfg_data;
                stpd_pkg::CFG_TONE_FLOOR: cfg_reg.tone_floor <= cfg_data[stpd_pkg::FREQ_W-1:0];
                stpd_pkg::CFG_TONE_BASE:  cfg_reg.tone_base  <= cfg_data[stpd_pkg::FREQ_W-1:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    stpd_front #(
        .HALF_BINS (HALF_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .entry      (push_entry),
        .inflight   (inflight)
    );

    stpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (push_entry),
        .pop      (pop),
        .rd_entry (head_entry),
        .inflight (inflight),
        .stat     (fifo_stat)
    );

    stpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .entry        (head_entry),
        .fifo_stat    (fifo_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // the credit check must keep the queue from ever overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("queue push while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.peak_count <= stpd_pkg::COUNT_MAX))
        else $error("peak count beyond saturation");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.peak_count == '0)
        |-> (result.tone_word == '0 && result.last_tone == '0))
        else $error("frame without peaks reports a tone");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");

endmodule

### verif/tb_top.sv
// Testbench for spectral_tone_peak_detector: random and directed FFT bin
// frames against an in-bench peak predictor, with stalls on both channels.
// Depends on stpd_pkg and the spectral_tone_peak_detector RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 10;
    localparam int          LONG_HOLD   = 400;
    localparam int          FRAME_BINS  = stpd_pkg::HALF_BINS_DEF;
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_ITEMS = 75;
    localparam logic [47:0] MAG_MAX     = 48'hFFFF_FFFF_FFFF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [stpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [stpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            item_valid = 1'b0;
    logic                            item_ready;
    stpd_pkg::item_t                 item = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    stpd_pkg::result_t               result;

    spectral_tone_peak_detector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the registers and the frame state
    logic [7:0]                   step_r;
    logic [stpd_pkg::MAG_W-1:0]   thresh_r;
    logic [stpd_pkg::FREQ_W-1:0]  floor_r;
    logic [stpd_pkg::FREQ_W-1:0]  base_r;
    logic [stpd_pkg::MAG_W-1:0]   mag_last;
    logic [stpd_pkg::MAG_W-1:0]   mag_older;
    int                           bin_pos;
    logic [stpd_pkg::WORD_W-1:0]  word_sum;
    logic [stpd_pkg::COUNT_W-1:0] peaks_seen;
    logic [stpd_pkg::FREQ_W-1:0]  tone_last;

    stpd_pkg::result_t tone_reports[$];
    stpd_pkg::item_t   bins_pending[$];

    int  cycles = 0;
    int  n_errors = 0;
    int  n_reported = 0;
    int  cfg_seen = 0;
    int  tx_issued = 0;
    int  tx_taken = 0;
    int  tx_gap = 0;
    int  rx_count = 0;
    int  rx_seen = 0;
    int  rx_gap = 0;
    int  hold_reqs = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;

    task automatic clear_frame();
        mag_last   = '0;
        mag_older  = '0;
        bin_pos    = 0;
        word_sum   = '0;
        peaks_seen = '0;
        tone_last  = '0;
    endtask

    // Advance the frame state by one bin; queue a report on the last bin
    task automatic detect_bin(input stpd_pkg::item_t it);
        longint                      re_v;
        longint                      im_v;
        longint                      fq;
        logic [stpd_pkg::MAG_W-1:0]  mag;
        logic [stpd_pkg::FREQ_W-1:0] freq;
        stpd_pkg::result_t           rep;
        re_v = longint'($signed(it.bin_re));
        im_v = longint'($signed(it.bin_im));
        mag  = stpd_pkg::MAG_W'(re_v * re_v + im_v * im_v);
        if (bin_pos >= 2)
        begin
            fq   = ((longint'(bin_pos) - 1) * longint'(step_r) / 2 + 50) / 100;
            freq = (fq > 4095) ? 12'd4095 : stpd_pkg::FREQ_W'(fq);
            if (freq > floor_r && mag_older < mag_last && mag_last > mag
                && mag_last > thresh_r)
            begin
                if (freq >= base_r && (freq - base_r) < 32)
                    word_sum[int'(freq - base_r)] = 1'b1;
                if (peaks_seen < stpd_pkg::COUNT_MAX)
                    peaks_seen = peaks_seen + 1'b1;
                tone_last = freq;
            end
        end
        mag_older = mag_last;
        mag_last  = mag;
        if (bin_pos < FRAME_BINS - 1)
            bin_pos++;
        if (it.last_bin)
        begin
            rep.tone_word  = word_sum;
            rep.peak_count = peaks_seen;
            rep.last_tone  = tone_last;
            tone_reports = {tone_reports, rep};
            clear_frame();
        end
    endtask

    // Input side acceptance, register writes and the run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL spectral_tone_peak_detector");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (stpd_pkg::cfg_idx_t'(cfg_index))
                    stpd_pkg::CFG_BIN_STEP:   step_r   = cfg_data[7:0];
                    stpd_pkg::CFG_THRESHOLD:  thresh_r = cfg_data[stpd_pkg::MAG_W-1:0];
                    stpd_pkg::CFG_TONE_FLOOR: floor_r  = cfg_data[stpd_pkg::FREQ_W-1:0];
                    stpd_pkg::CFG_TONE_BASE:  base_r   = cfg_data[stpd_pkg::FREQ_W-1:0];
                    default: ;
                endcase
                cfg_seen++;
            end
            if (item_valid && item_ready)
            begin
                detect_bin(item);
                tx_taken++;
            end
        end
    end

    // Result check against the oldest waiting report
    always @(posedge clk)
    begin
        stpd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            rx_count++;
            if (tone_reports.size() == 0)
            begin
                n_errors++;
                if (n_reported < 10)
                begin
                    n_reported++;
                    $display("unexpected result word %h count %0d tone %0d",
                             result.tone_word, result.peak_count, result.last_tone);
                end
            end
            else
            begin
                want = tone_reports.pop_front();
                if (want.tone_word !== result.tone_word
                    || want.peak_count !== result.peak_count
                    || want.last_tone !== result.last_tone)
                begin
                    n_errors++;
                    if (n_reported < 10)
                    begin
                        n_reported++;
                        $display("mismatch exp/got: word %h/%h count %0d/%0d tone %0d/%0d",
                                 want.tone_word, result.tone_word,
                                 want.peak_count, result.peak_count,
                                 want.last_tone, result.last_tone);
                    end
                end
            end
        end
    end

    // Bin driver: hold until taken, then wait the drawn gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && tx_issued != tx_taken)
                ;
            else if (tx_gap > 0)
            begin
                tx_gap--;
                item_valid <= 1'b0;
            end
            else if (bins_pending.size() > 0)
            begin
                item       <= bins_pending.pop_front();
                item_valid <= 1'b1;
                tx_issued++;
                tx_gap = calm ? 0 : $urandom_range(0, 11);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Result receiver: a drawn stall after each result, plus long holds on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_seen != rx_count)
            begin
                rx_seen = rx_count;
                rx_gap  = calm ? 0 : $urandom_range(0, 11);
            end
            if (hold_served != hold_reqs)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic write_reg(input stpd_pkg::cfg_idx_t idx,
                             input logic [stpd_pkg::CFG_DATA_W-1:0] val);
        int n0;
        n0 = cfg_seen;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        while (cfg_seen == n0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] step,
                             input logic [stpd_pkg::MAG_W-1:0] thr,
                             input logic [stpd_pkg::FREQ_W-1:0] flr,
                             input logic [stpd_pkg::FREQ_W-1:0] bas,
                             input bit junk);
        logic [stpd_pkg::CFG_DATA_W-1:0] hi;
        hi = junk ? stpd_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
        write_reg(stpd_pkg::CFG_BIN_STEP, {hi[stpd_pkg::CFG_DATA_W-1:8], step});
        write_reg(stpd_pkg::CFG_THRESHOLD, thr);
        write_reg(stpd_pkg::CFG_TONE_FLOOR,
                  {hi[stpd_pkg::CFG_DATA_W-1:stpd_pkg::FREQ_W], flr});
        write_reg(stpd_pkg::CFG_TONE_BASE,
                  {hi[stpd_pkg::CFG_DATA_W-1:stpd_pkg::FREQ_W], bas});
    endtask

    // Wait until every bin is taken and every report has arrived
    task automatic drain();
        while (bins_pending.size() != 0 || tx_issued != tx_taken
               || tone_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_bin(input int re_v, input int im_v, input bit last);
        stpd_pkg::item_t it;
        it.bin_re   = stpd_pkg::SMP_W'(re_v);
        it.bin_im   = stpd_pkg::SMP_W'(im_v);
        it.last_bin = last;
        bins_pending = {bins_pending, it};
    endtask

    function automatic int rand_amp(input int unsigned lo, input int unsigned hi);
        int a;
        a = int'($urandom_range(lo, hi));
        return $urandom_range(0, 1) ? -a : a;
    endfunction

    // One frame of low floor bins with scattered strong bins and plateaux
    task automatic queue_tone_frame(input int len);
        stpd_pkg::item_t it;
        stpd_pkg::item_t prev;
        int              pick;
        prev = '0;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && k > 0)
                it = prev;
            else if (pick < 35)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it.bin_re = stpd_pkg::SMP_W'(rand_amp(0, 8388607));
                    it.bin_im = stpd_pkg::SMP_W'(rand_amp(0, 8388607));
                end
                else
                begin
                    it.bin_re = stpd_pkg::SMP_W'(rand_amp(5000, 40000));
                    it.bin_im = stpd_pkg::SMP_W'(rand_amp(0, 20000));
                end
            end
            else
            begin
                it.bin_re = stpd_pkg::SMP_W'(rand_amp(0, 4000));
                it.bin_im = stpd_pkg::SMP_W'(rand_amp(0, 4000));
            end
            it.last_bin = (k == len - 1);
            bins_pending = {bins_pending, it};
            prev = it;
        end
    endtask

    // Raw bits, with frame ends falling anywhere
    task automatic queue_noise(input int len);
        stpd_pkg::item_t it;
        for (int k = 0; k < len; k++)
        begin
            it.bin_re   = stpd_pkg::SMP_W'($urandom);
            it.bin_im   = stpd_pkg::SMP_W'($urandom);
            it.last_bin = ($urandom_range(0, 7) == 0) || (k == len - 1);
            bins_pending = {bins_pending, it};
        end
    endtask

    initial
    begin
        int                         queued;
        int                         len;
        logic [7:0]                 step;
        logic [stpd_pkg::MAG_W-1:0] thr;
        logic [11:0]                flr;
        logic [11:0]                bas;

        step_r   = stpd_pkg::BIN_STEP_RST;
        thresh_r = stpd_pkg::THRESHOLD_RST;
        floor_r  = stpd_pkg::TONE_FLOOR_RST;
        base_r   = stpd_pkg::TONE_BASE_RST;
        clear_frame();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single bin frame at the sample extremes: empty report
        add_bin(8388607, -8388608, 1'b1);
        // Peak shape at reset settings, far below the floor
        add_bin(0, 0, 1'b0);
        add_bin(30000, 30000, 1'b0);
        add_bin(0, 0, 1'b1);
        drain();

        write_all(8'd255, '0, '0, 12'd2, 1'b0);
        // Strong first bin, plateau, full scale peak
        add_bin(5000, 0, 1'b0);
        add_bin(1, 1, 1'b0);
        add_bin(9000, -9000, 1'b0);
        add_bin(0, 0, 1'b0);
        add_bin(7000, 7000, 1'b0);
        add_bin(-7000, 7000, 1'b0);
        add_bin(0, 5, 1'b0);
        add_bin(-8388608, -8388608, 1'b0);
        add_bin(8388607, 0, 1'b0);
        add_bin(3, 4, 1'b1);
        drain();

        // Peaks all beneath the word base
        write_reg(stpd_pkg::CFG_TONE_BASE, 48'd4095);
        for (int k = 0; k < 6; k++)
            add_bin((k % 2) ? 20000 : 10, 0, k == 5);
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            step = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom_range(180, 255));
            case (p)
                2: thr = MAG_MAX;
                3: thr = '0;
                default: thr = $urandom_range(0, 1)
                               ? stpd_pkg::THRESHOLD_RST
                               : stpd_pkg::MAG_W'($urandom_range(0, 50000000));
            endcase
            flr = (p == 4) ? 12'd4095 : (p == 5) ? 12'd0 : 12'($urandom_range(0, 12));
            bas = (p == 6) ? 12'd4095 : (p == 7) ? 12'd0 : 12'($urandom_range(0, 20));
            write_all(step, thr, flr, bas, 1'b1);

            calm = (p == 3) || ($urandom_range(0, 3) == 0);
            if (p == 3)
                hold_reqs++;
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                if (p == 3)
                    len = $urandom_range(1, 4);
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(50, 200);
                else
                    len = $urandom_range(1, 20);
                if (p != 3 && $urandom_range(0, 4) == 0)
                    queue_noise(len);
                else
                    queue_tone_frame(len);
                queued += len;
            end
            drain();
        end

        if (n_errors == 0)
            $display("PASS spectral_tone_peak_detector");
        else
            $display("FAIL spectral_tone_peak_detector");
        $finish;
    end

endmodule

### filelist.f
rtl/core/stpd_pkg.sv
rtl/core/stpd_front.sv
rtl/core/stpd_fifo.sv
rtl/core/stpd_back.sv
rtl/core/spectral_tone_peak_detector.sv
verif/tb_top.sv
